>>> hdl/ipdfr_pkg.sv
package ipdfr_pkg;

  localparam int CmdWidth    = 2;
  localparam int ByteWidth   = 8;
  localparam int KindWidth   = 2;
  localparam int LengthWidth = 16;
  localparam int TicksWidth  = 16;

  // Command codes on the input channel.
  localparam logic [CmdWidth-1:0] CMD_START = 2'd0;
  localparam logic [CmdWidth-1:0] CMD_BYTE  = 2'd1;
  localparam logic [CmdWidth-1:0] CMD_TICK  = 2'd2;

  // Result kinds on the output channel.
  localparam logic [KindWidth-1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [KindWidth-1:0] KIND_TIMEOUT = 2'd1;
  localparam logic [KindWidth-1:0] KIND_EMPTY   = 2'd2;

  // Frame header "+IPD," split into its first four bytes and the closing comma.
  localparam logic [31:0]          HDR_FIRST4 = 32'h2B49_5044;
  localparam logic [ByteWidth-1:0] HDR_LAST   = 8'h2C;
  localparam logic [ByteWidth-1:0] COLON_CH   = 8'h3A;
  localparam logic [ByteWidth-1:0] DIGIT_ZERO = 8'h30;
  localparam logic [ByteWidth-1:0] DIGIT_NINE = 8'h39;

  localparam logic [TicksWidth-1:0] TIMEOUT_RESET = 16'd1000;

  typedef struct packed {
    logic [CmdWidth-1:0]  cmd;
    logic [ByteWidth-1:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic                   valid;
    logic [KindWidth-1:0]   result_kind;
    logic [ByteWidth-1:0]   data_byte;
    logic                   last;
    logic [LengthWidth-1:0] frame_length;
  } result_t;

endpackage

>>> hdl/ipdfr_cmd_if.sv
interface ipdfr_cmd_if import ipdfr_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CmdWidth-1:0]  cmd;
  logic [ByteWidth-1:0] rx_byte;

  modport source (output valid, output cmd, output rx_byte, input ready);
  modport sink (input valid, input cmd, input rx_byte, output ready);
endinterface

>>> hdl/ipdfr_result_if.sv
interface ipdfr_result_if import ipdfr_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [KindWidth-1:0]   result_kind;
  logic [ByteWidth-1:0]   data_byte;
  logic                   last;
  logic [LengthWidth-1:0] frame_length;

  modport source (output valid, output result_kind, output data_byte, output last,
                  output frame_length, input ready);
  modport sink (input valid, input result_kind, input data_byte, input last,
                input frame_length, output ready);
endinterface

>>> hdl/ipdfr_cfg_if.sv
interface ipdfr_cfg_if import ipdfr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [TicksWidth-1:0] timeout_ticks;

  modport source (output valid, output timeout_ticks, input ready);
  modport sink (input valid, input timeout_ticks, output ready);
endinterface

>>> hdl/ipdfr_deframer.sv
module ipdfr_deframer import ipdfr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  item_t                 item,
  input  logic [TicksWidth-1:0] timeout_ticks,
  output result_t               result
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HUNT,
    PH_LEN,
    PH_DATA
  } phase_t;

  phase_t                 phase, phase_next;
  logic [31:0]            recent_bytes, recent_bytes_next;
  logic [LengthWidth-1:0] length_acc, length_acc_next;
  logic                   digits_done, digits_done_next;
  logic [LengthWidth-1:0] payload_count, payload_count_next;
  logic [TicksWidth-1:0]  ticks_left, ticks_left_next;

  logic [LengthWidth+3:0] length_scaled;
  logic [LengthWidth-1:0] count_inc;
  logic [TicksWidth-1:0]  ticks_dec;

  // length * 10 + digit, as two shifted copies and the digit value.
  assign length_scaled = {1'b0, length_acc, 3'b000} + {3'b000, length_acc, 1'b0}
                       + {16'd0, item.rx_byte[3:0]};
  assign count_inc = payload_count + 1'b1;
  assign ticks_dec = (ticks_left != '0) ? ticks_left - 1'b1 : ticks_left;

  always_comb begin
    phase_next         = phase;
    recent_bytes_next  = recent_bytes;
    length_acc_next    = length_acc;
    digits_done_next   = digits_done;
    payload_count_next = payload_count;
    ticks_left_next    = ticks_left;
    result             = '0;

    case (item.cmd)
      CMD_START: begin
        recent_bytes_next  = '0;
        length_acc_next    = '0;
        digits_done_next   = 1'b0;
        payload_count_next = '0;
        ticks_left_next    = timeout_ticks;
        if (timeout_ticks == '0) begin
          phase_next         = PH_IDLE;
          result.valid       = 1'b1;
          result.result_kind = KIND_TIMEOUT;
          result.last        = 1'b1;
        end else begin
          phase_next = PH_HUNT;
        end
      end
      CMD_BYTE: begin
        case (phase)
          PH_HUNT: begin
            recent_bytes_next = {recent_bytes[23:0], item.rx_byte};
            if (recent_bytes == HDR_FIRST4 && item.rx_byte == HDR_LAST) begin
              phase_next       = PH_LEN;
              length_acc_next  = '0;
              digits_done_next = 1'b0;
            end
          end
          PH_LEN: begin
            if (item.rx_byte == COLON_CH) begin
              if (length_acc == '0) begin
                phase_next         = PH_IDLE;
                result.valid       = 1'b1;
                result.result_kind = KIND_EMPTY;
                result.last        = 1'b1;
              end else begin
                phase_next         = PH_DATA;
                payload_count_next = '0;
              end
            end else if (item.rx_byte inside {[DIGIT_ZERO:DIGIT_NINE]}) begin
              if (!digits_done) begin
                length_acc_next = (length_scaled[LengthWidth+3:LengthWidth] != '0)
                                ? '1 : length_scaled[LengthWidth-1:0];
              end
            end else begin
              digits_done_next = 1'b1;
            end
          end
          PH_DATA: begin
            payload_count_next  = count_inc;
            result.valid        = 1'b1;
            result.result_kind  = KIND_PAYLOAD;
            result.data_byte    = item.rx_byte;
            result.frame_length = length_acc;
            result.last         = (count_inc == length_acc);
            if (count_inc == length_acc) begin
              phase_next = PH_IDLE;
            end
          end
          default: begin
          end
        endcase
      end
      CMD_TICK: begin
        if (phase != PH_IDLE) begin
          ticks_left_next = ticks_dec;
          if (ticks_dec == '0) begin
            phase_next          = PH_IDLE;
            result.valid        = 1'b1;
            result.result_kind  = KIND_TIMEOUT;
            result.last         = 1'b1;
            result.frame_length = (phase == PH_DATA) ? length_acc : '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      recent_bytes  <= '0;
      length_acc    <= '0;
      digits_done   <= 1'b0;
      payload_count <= '0;
      ticks_left    <= '0;
    end else if (step) begin
      phase         <= phase_next;
      recent_bytes  <= recent_bytes_next;
      length_acc    <= length_acc_next;
      digits_done   <= digits_done_next;
      payload_count <= payload_count_next;
      ticks_left    <= ticks_left_next;
    end
  end

endmodule

>>> hdl/ipd_frame_receiver_unit.sv
// A word accepted into the input register is decoded by the deframer when it advances;
// its result, if any, is loaded into the result register, which offers it downstream.
// Throughput: one word per cycle while the result register is free or being emptied;
// every command is decoded in one pass through the deframer logic between both registers.
// Reset (rst, synchronous): empties both registers, returns the deframer to idle with
// all counters cleared and sets the tick budget to 1000.
module ipd_frame_receiver_unit import ipdfr_pkg::*; (
  input logic           clk,
  input logic           rst,
  ipdfr_cmd_if.sink     cmd_stream,
  ipdfr_result_if.source result_stream,
  ipdfr_cfg_if.sink     cfg
);

  logic [TicksWidth-1:0] budget;
  logic                  held_valid;
  item_t                 held_item;
  logic                  advance;
  result_t               step_result;
  result_t               out_reg;

  // The held word moves on whenever the result register is free or being emptied.
  assign advance          = held_valid && (!out_reg.valid || result_stream.ready);
  assign cmd_stream.ready = !held_valid || advance;
  assign cfg.ready        = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      budget <= TIMEOUT_RESET;
    end else if (cfg.valid) begin
      budget <= cfg.timeout_ticks;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (cmd_stream.valid && cmd_stream.ready) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
    if (cmd_stream.valid && cmd_stream.ready) begin
      held_item.cmd     <= cmd_stream.cmd;
      held_item.rx_byte <= cmd_stream.rx_byte;
    end
  end

  ipdfr_deframer u_deframer (
    .clk           (clk),
    .rst           (rst),
    .step          (advance),
    .item          (held_item),
    .timeout_ticks (budget),
    .result        (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_reg.valid <= 1'b0;
    end else if (advance && step_result.valid) begin
      out_reg.valid <= 1'b1;
    end else if (result_stream.ready) begin
      out_reg.valid <= 1'b0;
    end
    if (advance && step_result.valid) begin
      out_reg.result_kind  <= step_result.result_kind;
      out_reg.data_byte    <= step_result.data_byte;
      out_reg.last         <= step_result.last;
      out_reg.frame_length <= step_result.frame_length;
    end
  end

  assign result_stream.valid        = out_reg.valid;
  assign result_stream.result_kind  = out_reg.result_kind;
  assign result_stream.data_byte    = out_reg.data_byte;
  assign result_stream.last         = out_reg.last;
  assign result_stream.frame_length = out_reg.frame_length;

`ifndef ASSERT_OFF
  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    advance && step_result.valid |=> result_stream.valid)
    else $error("result of a processed word did not reach the output");

  a_held_word_kept: assert property (@(posedge clk) disable iff (rst)
    held_valid && !advance |=> held_valid && $stable(held_item))
    else $error("stalled word in the input register was lost or changed");

  a_end_marks_last: assert property (@(posedge clk) disable iff (rst)
    result_stream.valid && result_stream.result_kind != KIND_PAYLOAD |-> result_stream.last)
    else $error("terminating result without last");

  a_end_no_data: assert property (@(posedge clk) disable iff (rst)
    result_stream.valid && result_stream.result_kind != KIND_PAYLOAD
      |-> result_stream.data_byte == '0)
    else $error("terminating result carries a data byte");
`endif

endmodule
